[rtl/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, constants and helpers for the TGA run-length packet encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgarle_pkg;

	localparam int PIX_W     = 32;  // pixel width
	localparam int CNT_W     = 8;   // pixel counts, up to 128
	localparam int BPP_W     = 3;   // bytes_per_pixel register
	localparam int HDR_W     = 8;   // packet header
	localparam int HCNT_W    = 7;   // count field of the header
	localparam int LCNT_W    = 3;   // lane_count width
	localparam int OUT_LANES = 4;   // pixel slots per result
	localparam int LANE_W    = 2;   // lane index width
	localparam int TOK_SLOTS = 4;   // commands one pixel can raise (3 used)
	localparam int SLOT_W    = 2;
	localparam int Q_DEPTH   = 4;   // command queue depth
	localparam int Q_PTR_W   = 2;

	localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;
	localparam logic [HDR_W-1:0] HDR_RUN   = 8'h80;

	// command passed from the classifier to the packet builder
	typedef enum logic [1:0] {
		TK_PUSH  = 2'd0,  // store pixel at cnt, flush after it if do_flush
		TK_FLUSH = 2'd1,  // send cnt buffered pixels as one raw packet
		TK_RUN   = 2'd2   // send a run packet of cnt copies of pixel
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [PIX_W-1:0]   pixel;
		logic [CNT_W-1:0]   cnt;
		logic               do_flush;
		logic               item_last;  // last result-producing command of a pixel
		logic               row_end;    // ... and that pixel closed the row
	} tok_t;

	function automatic logic [PIX_W-1:0] pixel_mask(input logic [BPP_W-1:0] bpp);
		logic [PIX_W-1:0] m;
		unique case (bpp)
			3'd0, 3'd1: m = 32'h0000_00FF;
			3'd2:       m = 32'h0000_FFFF;
			3'd3:       m = 32'h00FF_FFFF;
			default:    m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic tok_t mk_tok(input tok_kind_t kind, input logic [PIX_W-1:0] pixel,
	                                input logic [CNT_W-1:0] cnt, input logic do_flush);
		tok_t t;
		t.kind      = kind;
		t.pixel     = pixel;
		t.cnt       = cnt;
		t.do_flush  = do_flush;
		t.item_last = 1'b0;
		t.row_end   = 1'b0;
		return t;
	endfunction

endpackage

[rtl/tgarle_if.sv]
// ----------------------------------------------------------------------------
// tgarle_if
// Valid/ready channels: pixel input and packet result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tgarle_pix_if;
	import tgarle_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             row_end;
	modport source (output valid, pixel_value, row_end, input ready);
	modport sink   (input valid, pixel_value, row_end, output ready);
endinterface

interface tgarle_pkt_if;
	import tgarle_pkg::*;
	logic              valid;
	logic              ready;
	logic              has_header;
	logic [HDR_W-1:0]  packet_header;
	logic [LCNT_W-1:0] lane_count;
	logic [PIX_W-1:0]  pixel_a;
	logic [PIX_W-1:0]  pixel_b;
	logic [PIX_W-1:0]  pixel_c;
	logic [PIX_W-1:0]  pixel_d;
	logic              row_done;
	logic              last_result;
	modport source (output valid, has_header, packet_header, lane_count, pixel_a, pixel_b,
	                pixel_c, pixel_d, row_done, last_result, input ready);
	modport sink   (input valid, has_header, packet_header, lane_count, pixel_a, pixel_b,
	                pixel_c, pixel_d, row_done, last_result, output ready);
endinterface

[rtl/tgarle_front.sv]
// ----------------------------------------------------------------------------
// tgarle_front
// Pixel classifier: tracks the pending run and raw fill, turns each pixel
// into up to three commands and feeds them to the queue one per cycle while it is not full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgarle_front #(
	parameter int MAX_PACKET = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tgarle_pkg::BPP_W-1:0] cfg_wdata,
	tgarle_pix_if.sink                  pix,
	output logic                        q_push,
	output tgarle_pkg::tok_t            q_wdata,
	input  logic                        q_full
);
	import tgarle_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET);

	logic [BPP_W-1:0]  bpp_q;
	logic [PIX_W-1:0]  held_q;
	logic              held_valid_q;
	logic [CNT_W-1:0]  run_cnt_q;
	logic [CNT_W-1:0]  raw_cnt_q;
	tok_t              pend_q [TOK_SLOTS];
	logic [SLOT_W:0]   pend_cnt_q;
	logic [SLOT_W-1:0] pend_idx_q;

	logic [PIX_W-1:0]  mask;
	logic [PIX_W-1:0]  pix_m;
	logic              match;
	logic              c_hv;
	logic [PIX_W-1:0]  c_hp;
	logic [CNT_W-1:0]  c_rc;
	logic [CNT_W-1:0]  c_raw;
	logic [CNT_W-1:0]  c_rawn;
	tok_t              c_tok [TOK_SLOTS];
	logic [SLOT_W:0]   c_n;
	logic [SLOT_W-1:0] fin_idx;
	logic              fin_any;
	logic              accept;

	always_comb begin
		mask   = pixel_mask(bpp_q);
		pix_m  = pix.pixel_value & mask;
		match  = ((held_q ^ pix_m) & mask) == '0;
		c_hv   = held_valid_q;
		c_hp   = held_q;
		c_rc   = run_cnt_q;
		c_raw  = raw_cnt_q;
		c_rawn = '0;
		c_n    = '0;
		for (int i = 0; i < TOK_SLOTS; i++) begin
			c_tok[i] = '0;
		end

		if (!c_hv) begin
			c_hp = pix_m;
			c_hv = 1'b1;
			c_rc = CNT_W'(1);
		end else if (match) begin
			// a run starts: whatever raw pixels wait go out first
			if (c_rc == CNT_W'(1) && c_raw != '0) begin
				c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_FLUSH, '0, c_raw, 1'b0);
				c_n   = c_n + (SLOT_W+1)'(1);
				c_raw = '0;
			end
			c_rc = c_rc + CNT_W'(1);
			if (c_rc >= MAX_CNT) begin
				c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_RUN, c_hp, c_rc, 1'b0);
				c_n  = c_n + (SLOT_W+1)'(1);
				c_hv = 1'b0;
				c_rc = '0;
			end
		end else begin
			if (c_rc >= CNT_W'(2)) begin
				c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_RUN, c_hp, c_rc, 1'b0);
				c_n = c_n + (SLOT_W+1)'(1);
			end else begin
				c_rawn = c_raw + CNT_W'(1);
				c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_PUSH, c_hp, c_raw, c_rawn == MAX_CNT);
				c_n   = c_n + (SLOT_W+1)'(1);
				c_raw = (c_rawn == MAX_CNT) ? '0 : c_rawn;
			end
			c_hp = pix_m;
			c_hv = 1'b1;
			c_rc = CNT_W'(1);
		end

		// row end closes everything that is pending
		if (pix.row_end) begin
			if (c_hv) begin
				if (c_rc >= CNT_W'(2)) begin
					if (c_raw != '0) begin
						c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_FLUSH, '0, c_raw, 1'b0);
						c_n   = c_n + (SLOT_W+1)'(1);
						c_raw = '0;
					end
					c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_RUN, c_hp, c_rc, 1'b0);
					c_n = c_n + (SLOT_W+1)'(1);
				end else begin
					c_rawn = c_raw + CNT_W'(1);
					c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_PUSH, c_hp, c_raw, c_rawn == MAX_CNT);
					c_n   = c_n + (SLOT_W+1)'(1);
					c_raw = (c_rawn == MAX_CNT) ? '0 : c_rawn;
				end
			end
			if (c_raw != '0) begin
				c_tok[c_n[SLOT_W-1:0]] = mk_tok(TK_FLUSH, '0, c_raw, 1'b0);
				c_n = c_n + (SLOT_W+1)'(1);
			end
			c_raw = '0;
			c_hv  = 1'b0;
			c_rc  = '0;
		end

		// tag the last command of this pixel that yields results
		fin_any = 1'b0;
		fin_idx = '0;
		for (int i = 0; i < TOK_SLOTS; i++) begin
			if ((SLOT_W+1)'(i) < c_n &&
			    (c_tok[i].kind != TK_PUSH || c_tok[i].do_flush)) begin
				fin_any = 1'b1;
				fin_idx = SLOT_W'(i);
			end
		end
		if (fin_any) begin
			c_tok[fin_idx].item_last = 1'b1;
			c_tok[fin_idx].row_end   = pix.row_end;
		end
	end

	assign q_push    = (pend_cnt_q != '0) && !q_full;
	assign q_wdata   = pend_q[pend_idx_q];
	assign pix.ready = (pend_cnt_q == '0) || (pend_cnt_q == (SLOT_W+1)'(1) && !q_full);
	assign accept    = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q        <= BPP_RESET;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			run_cnt_q    <= '0;
			raw_cnt_q    <= '0;
			pend_cnt_q   <= '0;
			pend_idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				bpp_q <= cfg_wdata;
			end
			if (accept) begin
				held_q       <= c_hp;
				held_valid_q <= c_hv;
				run_cnt_q    <= c_rc;
				raw_cnt_q    <= c_raw;
				pend_cnt_q   <= c_n;
				pend_idx_q   <= '0;
			end else if (q_push) begin
				pend_cnt_q <= pend_cnt_q - (SLOT_W+1)'(1);
				pend_idx_q <= pend_idx_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= c_tok;
		end
	end

endmodule

[rtl/tgarle_fifo.sv]
// ----------------------------------------------------------------------------
// tgarle_fifo
// Short command queue between classifier and packet builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgarle_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tgarle_pkg::tok_t wdata,
	output logic             full,
	input  logic             pop,
	output tgarle_pkg::tok_t rdata,
	output logic             empty
);
	import tgarle_pkg::*;

	tok_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

[rtl/tgarle_back.sv]
// ----------------------------------------------------------------------------
// tgarle_back
// Packet builder: raw pixel buffer (rows of four lanes), run packets and
// raw packet drain into a registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgarle_back #(
	parameter int MAX_PACKET = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tgarle_pkg::tok_t q_rdata,
	input  logic             q_empty,
	output logic             q_pop,
	tgarle_pkt_if.source     pkt
);
	import tgarle_pkg::*;

	localparam int ROWS = (MAX_PACKET + OUT_LANES - 1) / OUT_LANES;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t                             state_q;
	logic [OUT_LANES-1:0][PIX_W-1:0]    raw_mem [ROWS];
	logic [OUT_LANES-1:0][PIX_W-1:0]    rd_data_q;
	logic [RW-1:0]                      row_q;
	logic [CNT_W-1:0]                   total_q;
	logic                               fl_last_q;
	logic                               fl_row_q;

	logic                               out_valid_q;
	logic                               hh_q;
	logic [HDR_W-1:0]                   hdr_q;
	logic [LCNT_W-1:0]                  lanes_q;
	logic [OUT_LANES-1:0][PIX_W-1:0]    px_q;
	logic                               row_done_q;
	logic                               last_q;

	logic                               has_tok;
	logic                               wr_en;
	logic                               out_free;
	logic                               ld_run;
	logic                               ld_raw;
	logic                               start_fl;
	logic [CNT_W-1:0]                   rem;
	logic                               last_row;
	logic [LCNT_W-1:0]                  lanes;

	assign has_tok  = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || pkt.ready;
	assign wr_en    = has_tok && q_rdata.kind == TK_PUSH;
	assign ld_run   = has_tok && q_rdata.kind == TK_RUN && out_free;
	assign start_fl = has_tok && (q_rdata.kind == TK_FLUSH ||
	                              (q_rdata.kind == TK_PUSH && q_rdata.do_flush));
	assign q_pop    = has_tok && (q_rdata.kind != TK_RUN || out_free);
	assign ld_raw   = (state_q == ST_SEND) && out_free;

	assign rem      = total_q - CNT_W'({row_q, {LANE_W{1'b0}}});
	assign last_row = rem <= CNT_W'(OUT_LANES);
	assign lanes    = last_row ? rem[LCNT_W-1:0] : LCNT_W'(OUT_LANES);

	// raw buffer: one lane written per push, one row read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			raw_mem[q_rdata.cnt[LANE_W +: RW]][q_rdata.cnt[LANE_W-1:0]] <= q_rdata.pixel;
		end
		rd_data_q <= raw_mem[row_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			total_q     <= '0;
			fl_last_q   <= 1'b0;
			fl_row_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_run || ld_raw) begin
				out_valid_q <= 1'b1;
			end else if (pkt.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_fl) begin
						total_q   <= (q_rdata.kind == TK_FLUSH) ? q_rdata.cnt
						                                        : q_rdata.cnt + CNT_W'(1);
						row_q     <= '0;
						fl_last_q <= q_rdata.item_last;
						fl_row_q  <= q_rdata.row_end;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						if (last_row) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + RW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld_run) begin
			hh_q       <= 1'b1;
			hdr_q      <= HDR_RUN | {1'b0, HCNT_W'(q_rdata.cnt - CNT_W'(1))};
			lanes_q    <= LCNT_W'(1);
			px_q       <= {{((OUT_LANES-1)*PIX_W){1'b0}}, q_rdata.pixel};
			row_done_q <= q_rdata.row_end;
			last_q     <= q_rdata.item_last;
		end else if (ld_raw) begin
			hh_q       <= row_q == '0;
			hdr_q      <= (row_q == '0) ? {1'b0, HCNT_W'(total_q - CNT_W'(1))} : '0;
			lanes_q    <= lanes;
			for (int k = 0; k < OUT_LANES; k++) begin
				px_q[k] <= (LCNT_W'(k) < lanes) ? rd_data_q[k] : '0;
			end
			row_done_q <= last_row && fl_row_q;
			last_q     <= last_row && fl_last_q;
		end
	end

	assign pkt.valid         = out_valid_q;
	assign pkt.has_header    = hh_q;
	assign pkt.packet_header = hdr_q;
	assign pkt.lane_count    = lanes_q;
	assign pkt.pixel_a       = px_q[0];
	assign pkt.pixel_b       = px_q[1];
	assign pkt.pixel_c       = px_q[2];
	assign pkt.pixel_d       = px_q[3];
	assign pkt.row_done      = row_done_q;
	assign pkt.last_result   = last_q;

endmodule

[rtl/tga_rle_packet_encoder_top.sv]
// ----------------------------------------------------------------------------
// tga_rle_packet_encoder_top
// Result path: a run packet result passes the classifier's command register,
//   the queue and the result register; a raw packet result also passes a row read.
// Throughput: 1 pixel per cycle while pixels only extend a packet; the next
//   pixel waits until the last command of one enters the queue; a raw packet
//   drains each result as a row read of the raw buffer, then a result register load.
// Reset: arst_n clears run/raw tracking, queue and output valid, and sets
//   bytes_per_pixel to 3; raw buffer contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_rle_packet_encoder_top #(
	parameter int MAX_PACKET = 128  // pixels per packet, 2..128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tgarle_pkg::BPP_W-1:0] cfg_wdata,
	tgarle_pix_if.sink                   pix_in,
	tgarle_pkt_if.source                 pkt_out
);
	import tgarle_pkg::*;

	// Front: classifies each pixel against the pending run and emits up to
	// three commands (push to raw buffer, flush raw packet, run packet).
	// The last command that yields results carries the per-pixel and
	// per-row end marks, so the builder never has to look ahead.
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	tok_t q_wdata;
	tok_t q_rdata;

	tgarle_front #(
		.MAX_PACKET (MAX_PACKET)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_in),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.q_full    (q_full)
	);

	// Command queue: lets the classifier keep taking pixels while the
	// builder drains a raw packet or waits on a stalled output.
	tgarle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back: owns the raw buffer and the result register; one transfer on
	// pkt_out per result, four pixel slots wide.
	tgarle_back #(
		.MAX_PACKET (MAX_PACKET)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rdata (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pkt     (pkt_out)
	);

endmodule
